### hdl/quantized_feature_multimatch_table_top_assert.svh
`ifndef QUANTIZED_FEATURE_MULTIMATCH_TABLE_TOP_ASSERT_SVH
`define QUANTIZED_FEATURE_MULTIMATCH_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QFMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qfmm assertion failed");

// next-cycle implication, checked out of reset
`define QFMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qfmm assertion failed");

`endif

### hdl/qfmm_pkg.sv
`default_nettype none
package qfmm_pkg;

    localparam int SIDE        = 32;
    localparam int ENTRIES     = 1024;
    localparam int MAX_MATCHES = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W   = $clog2(ENTRIES + 1);
    localparam int NMATCH_W  = $clog2(MAX_MATCHES + 1);
    localparam int IDX_W     = 5;
    localparam int STEP_W    = 31;
    localparam int DIV_STEPS = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    localparam logic [31:0]       MINUS_ONE_Q16       = 32'hFFFF_0000;
    localparam logic [STEP_W-1:0] ANGLE_STEP_RESET    = 31'd13724;
    localparam logic [STEP_W-1:0] DISTANCE_STEP_RESET = 31'd655;

    localparam logic REG_ANGLE_STEP    = 1'b0;
    localparam logic REG_DISTANCE_STEP = 1'b1;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] feature_angle_1;
        logic signed [31:0] feature_angle_2;
        logic signed [31:0] feature_angle_3;
        logic signed [31:0] feature_distance;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               match_found;
        logic [IDX_W-1:0]   match_row;
        logic [IDX_W-1:0]   match_col;
        logic               last;
        logic               truncated;
        logic signed [31:0] max_distance;
    } out_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [63:0]        key;
        logic [2*IDX_W-1:0] idx;
        logic [31:0]        distance;
    } q_entry_t;

    function automatic logic [IDX_W-1:0] clamp_side(input logic [IDX_W-1:0] x);
        logic [8:0] w;
        w = 9'(x);
        return (w >= 9'(SIDE)) ? IDX_W'(SIDE - 1) : x;
    endfunction

    function automatic out_t make_out(input logic [1:0] st, input logic found,
                                      input logic [2*IDX_W-1:0] idx, input logic lst,
                                      input logic trunc, input logic [31:0] maxd);
        out_t o;
        o.status       = st;
        o.match_found  = found;
        o.match_row    = idx[2*IDX_W-1:IDX_W];
        o.match_col    = idx[IDX_W-1:0];
        o.last         = lst;
        o.truncated    = trunc;
        o.max_distance = maxd;
        return o;
    endfunction

endpackage
`default_nettype wire

### hdl/qfmm_quant.sv
`default_nettype none
module qfmm_quant import qfmm_pkg::*; (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire [31:0]        value,
    input  wire [STEP_W-1:0]  step,
    output logic              busy,
    output logic [15:0]       bucket
);

    logic              busy_reg, busy_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [31:0]       quo_reg, quo_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       trial;
    logic [31:0]       diff;
    logic [32:0]       mag;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, step_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = value[31];
            quo_next  = value[31] ? (32'd0 - value) : value;
            rem_next  = '0;
            step_next = step;
        end else if (busy_reg) begin
            if (trial >= {1'b0, step_reg}) begin
                rem_next = diff[STEP_W-1:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[STEP_W-1:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    // floor for negatives: -(q + (r != 0)), then saturate
    always_comb begin
        mag = {1'b0, quo_reg} + 33'(neg_reg && (rem_reg != '0));
        if (!neg_reg) begin
            bucket = (mag > 33'd32767) ? 16'h7FFF : mag[15:0];
        end else begin
            bucket = (mag > 33'd32768) ? 16'h8000 : 16'(17'd0 - mag[16:0]);
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

### hdl/qfmm_fifo.sv
`default_nettype none
module qfmm_fifo import qfmm_pkg::*; (
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      push,
    input  q_entry_t push_entry,
    output logic     full,
    input  wire      pop,
    output q_entry_t head,
    output logic     empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            slots[wr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

### hdl/qfmm_front.sv
`default_nettype none
module qfmm_front import qfmm_pkg::*; (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    input  wire [STEP_W-1:0] angle_step,
    input  wire [STEP_W-1:0] distance_step,
    output logic             push,
    output q_entry_t         push_entry,
    input  wire              full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } f_state_t;

    f_state_t           state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [2*IDX_W-1:0] idx_reg;
    logic [31:0]        dist_reg;
    logic               accept, start;
    logic [STEP_W-1:0]  a_step, d_step;
    logic [3:0]         busy;
    logic [15:0]        b0, b1, b2, b3;

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;
    assign start   = accept && (s_data.command == CMD_INSERT || s_data.command == CMD_LOOKUP);
    assign a_step  = (angle_step == '0) ? STEP_W'(1) : angle_step;
    assign d_step  = (distance_step == '0) ? STEP_W'(1) : distance_step;

    qfmm_quant u_q0 (.aclk, .aresetn, .start, .value(s_data.feature_angle_1),
                     .step(a_step), .busy(busy[0]), .bucket(b0));
    qfmm_quant u_q1 (.aclk, .aresetn, .start, .value(s_data.feature_angle_2),
                     .step(a_step), .busy(busy[1]), .bucket(b1));
    qfmm_quant u_q2 (.aclk, .aresetn, .start, .value(s_data.feature_angle_3),
                     .step(a_step), .busy(busy[2]), .bucket(b2));
    qfmm_quant u_q3 (.aclk, .aresetn, .start, .value(s_data.feature_distance),
                     .step(d_step), .busy(busy[3]), .bucket(b3));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = start ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (busy == 4'b0000) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (accept) begin
            cmd_reg  <= s_data.command;
            idx_reg  <= {clamp_side(s_data.row_index), clamp_side(s_data.col_index)};
            dist_reg <= s_data.feature_distance;
        end
    end

    assign push                = (state_reg == F_PUSH);
    assign push_entry.cmd      = cmd_reg;
    assign push_entry.key      = {b0, b1, b2, b3};
    assign push_entry.idx      = idx_reg;
    assign push_entry.distance = dist_reg;

endmodule
`default_nettype wire

### hdl/qfmm_back.sv
`default_nettype none
module qfmm_back import qfmm_pkg::*; (
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      q_empty,
    input  q_entry_t q_head,
    output logic     pop,
    output logic     m_valid,
    input  wire      m_ready,
    output out_t     m_data
);

`include "quantized_feature_multimatch_table_top_assert.svh"

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_SCAN = 3'b010,
        B_FIN  = 3'b100
    } b_state_t;

    logic [63:0]        key_mem [ENTRIES];
    logic [2*IDX_W-1:0] idx_mem [ENTRIES];

    b_state_t           state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        maxd_reg, maxd_next;
    logic               loaded_reg, loaded_next;
    logic [COUNT_W-1:0] addr_reg, addr_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [63:0]        rd_key_reg;
    logic [2*IDX_W-1:0] rd_idx_reg;
    logic [63:0]        key_reg, key_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [2*IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [NMATCH_W-1:0] nm_reg, nm_next;
    logic               o_valid_reg, o_valid_next;
    out_t               o_data_reg, o_data_next;
    logic               out_free, hit, at_limit, wr_en, rd_en;
    logic [31:0]        new_maxd;

    assign out_free = !o_valid_reg || m_ready;
    assign hit      = rd_valid_reg && (rd_key_reg == key_reg);
    assign at_limit = (nm_reg == NMATCH_W'(MAX_MATCHES));
    assign new_maxd = ($signed(q_head.distance) > $signed(maxd_reg)) ? q_head.distance
                                                                     : maxd_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        maxd_next       = maxd_reg;
        loaded_next     = loaded_reg;
        addr_next       = addr_reg;
        rd_valid_next   = rd_valid_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        nm_next         = nm_reg;
        o_valid_next    = o_valid_reg && !m_ready;
        o_data_next     = o_data_reg;
        pop             = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty && out_free) begin
                    pop          = 1'b1;
                    o_valid_next = 1'b1;
                    o_data_next  = make_out(ST_OK, 1'b0, '0, 1'b1, 1'b0, maxd_reg);
                    unique case (q_head.cmd)
                        CMD_CLEAR: begin
                            count_next  = '0;
                            maxd_next   = MINUS_ONE_Q16;
                            loaded_next = 1'b1;
                            o_data_next = make_out(ST_OK, 1'b0, '0, 1'b1, 1'b0, MINUS_ONE_Q16);
                        end
                        CMD_INSERT: begin
                            if (!loaded_reg) begin
                                o_data_next.status = ST_NOT_LOADED;
                            end else if (count_reg == COUNT_W'(ENTRIES)) begin
                                o_data_next.status = ST_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + COUNT_W'(1);
                                maxd_next   = new_maxd;
                                o_data_next.max_distance = new_maxd;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (!loaded_reg) begin
                                o_data_next.status = ST_NOT_LOADED;
                            end else begin
                                o_valid_next    = o_valid_reg && !m_ready;
                                o_data_next     = o_data_reg;
                                key_next        = q_head.key;
                                addr_next       = '0;
                                rd_valid_next   = 1'b0;
                                pend_valid_next = 1'b0;
                                nm_next         = '0;
                                state_next      = B_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_SCAN: begin
                if (!rd_valid_reg && addr_reg == count_reg) begin
                    state_next = B_FIN;
                end else if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit && pend_valid_reg && at_limit) begin
                        // one match beyond the limit: close out with truncation
                        o_valid_next  = 1'b1;
                        o_data_next   = make_out(ST_OK, 1'b1, pend_idx_reg, 1'b1, 1'b1,
                                                 maxd_reg);
                        rd_valid_next = 1'b0;
                        state_next    = B_IDLE;
                    end else begin
                        if (hit) begin
                            if (pend_valid_reg) begin
                                o_valid_next = 1'b1;
                                o_data_next  = make_out(ST_OK, 1'b1, pend_idx_reg, 1'b0,
                                                        1'b0, maxd_reg);
                            end
                            pend_valid_next = 1'b1;
                            pend_idx_next   = rd_idx_reg;
                            nm_next         = nm_reg + NMATCH_W'(1);
                        end
                        if (addr_reg < count_reg) begin
                            rd_en         = 1'b1;
                            addr_next     = addr_reg + COUNT_W'(1);
                            rd_valid_next = 1'b1;
                        end else begin
                            rd_valid_next = 1'b0;
                        end
                    end
                end
            end
            B_FIN: begin
                if (out_free) begin
                    o_valid_next = 1'b1;
                    o_data_next  = make_out(ST_OK, pend_valid_reg,
                                            pend_valid_reg ? pend_idx_reg : '0,
                                            1'b1, 1'b0, maxd_reg);
                    state_next   = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            maxd_reg       <= MINUS_ONE_Q16;
            loaded_reg     <= 1'b0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            nm_reg         <= '0;
            o_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            maxd_reg       <= maxd_next;
            loaded_reg     <= loaded_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            nm_reg         <= nm_next;
            o_valid_reg    <= o_valid_next;
        end
        addr_reg     <= addr_next;
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        o_data_reg   <= o_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[count_reg[ADDR_W-1:0]] <= q_head.key;
            idx_mem[count_reg[ADDR_W-1:0]] <= q_head.idx;
        end
        if (rd_en) begin
            rd_key_reg <= key_mem[addr_reg[ADDR_W-1:0]];
            rd_idx_reg <= idx_mem[addr_reg[ADDR_W-1:0]];
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

    `QFMM_ASSERT_NOW(a_scan_loaded, state_reg != B_IDLE, loaded_reg)
    `QFMM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(ENTRIES))
    `QFMM_ASSERT_NOW(a_pend_counted, pend_valid_reg, nm_reg != '0)
    `QFMM_ASSERT_NEXT(a_fin_done, state_reg == B_FIN && out_free, state_reg == B_IDLE && o_valid_reg)

endmodule
`default_nettype wire

### hdl/quantized_feature_multimatch_table_top.sv
// Insert and lookup commands have their key quantized in serial dividers before they are
// queued; clear and unknown commands skip the dividers.
// Lookup: the scan reads the stored entries in order and ends with a last-flagged result.
// The front takes a new command only once the last one has been pushed into the queue;
// lookups are then bound by the one-entry-per-cycle scan, held while a match awaits output.
// Reset (aresetn low, synchronous): table empty and not loaded, max distance -1.0,
// steps back to their defaults. Store contents are not cleared.
`default_nettype none
module quantized_feature_multimatch_table_top import qfmm_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    output logic       m_valid,
    input  wire        m_ready,
    output out_t       m_data,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [2:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    logic [STEP_W-1:0] angle_step_reg, distance_step_reg;
    logic              cfg_wr;
    logic              push, full, pop, empty;
    q_entry_t          push_entry, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_step_reg    <= ANGLE_STEP_RESET;
            distance_step_reg <= DISTANCE_STEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ANGLE_STEP) begin
                angle_step_reg <= pwdata[STEP_W-1:0];
            end else begin
                distance_step_reg <= pwdata[STEP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ANGLE_STEP) ? {1'b0, angle_step_reg}
                                                 : {1'b0, distance_step_reg};

    qfmm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .angle_step(angle_step_reg), .distance_step(distance_step_reg),
        .push, .push_entry, .full
    );

    qfmm_fifo u_fifo (
        .aclk, .aresetn, .push, .push_entry, .full, .pop, .head, .empty
    );

    qfmm_back u_back (
        .aclk, .aresetn, .q_empty(empty), .q_head(head), .pop,
        .m_valid, .m_ready, .m_data
    );

endmodule
`default_nettype wire
